[rtl/blank_row_column_removal_core_defines.svh]
// ----------------------------------------------------------------------------
// blank row and column removal: assertion macros
// shared concurrent assertion forms used by the core
// ----------------------------------------------------------------------------
`ifndef BLANK_ROW_COLUMN_REMOVAL_CORE_DEFINES_SVH
`define BLANK_ROW_COLUMN_REMOVAL_CORE_DEFINES_SVH

// same-cycle implication
`define BRRC_ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRRC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/brrc_pkg.sv]
// ----------------------------------------------------------------------------
// brrc_pkg
// types, constants and helpers shared by the blank row/column removal core
// ----------------------------------------------------------------------------
package brrc_pkg;

  localparam int unsigned DEF_MAX_ROWS    = 64;
  localparam int unsigned DEF_MAX_COLUMNS = 64;

  localparam int unsigned SIZE_W      = 7;   // height / width register width
  localparam int unsigned LEN_W       = 7;   // row_length field width
  localparam int unsigned ROW_BITS_W  = 64;  // row_bits field width
  localparam int unsigned CMP_W       = 9;   // compare width for counters vs sizes
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned SIZE_RESET  = 64;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_READ,
    ST_PACK,
    ST_EMIT,
    ST_EMPTY
  } seq_state_t;

  typedef struct packed {
    logic              start;
    logic [SIZE_W-1:0] width;
  } pack_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pack_sts_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int unsigned max_v);
    logic [SIZE_W-1:0] s;
    s = v;
    if (v == '0) begin
      s = SIZE_W'(1);
    end else if (32'(v) > max_v) begin
      s = SIZE_W'(max_v);
    end
    return s;
  endfunction

endpackage

[rtl/brrc_row_mem.sv]
// ----------------------------------------------------------------------------
// brrc_row_mem
// one-write, one-read row store with registered read data
// ----------------------------------------------------------------------------
module brrc_row_mem #(
  parameter int unsigned DEPTH = brrc_pkg::DEF_MAX_ROWS,
  parameter int unsigned WIDTH = brrc_pkg::DEF_MAX_COLUMNS,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/brrc_packer.sv]
// ----------------------------------------------------------------------------
// brrc_packer
// bit-serial compactor: keeps the masked columns of one row, one column a cycle
// ----------------------------------------------------------------------------
module brrc_packer #(
  parameter int unsigned MAX_COLUMNS = brrc_pkg::DEF_MAX_COLUMNS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  brrc_pkg::pack_ctl_t       ctl,
  input  logic [MAX_COLUMNS-1:0]    row_word,
  input  logic [MAX_COLUMNS-1:0]    mask,
  output logic [MAX_COLUMNS-1:0]    bits,
  output logic [brrc_pkg::LEN_W-1:0] len,
  output brrc_pkg::pack_sts_t       sts
);
  import brrc_pkg::*;

  localparam int unsigned COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic                   busy;
  logic                   done;
  logic [COL_W-1:0]       col;
  logic [LEN_W-1:0]       kept;
  logic [MAX_COLUMNS-1:0] row_sh;
  logic [MAX_COLUMNS-1:0] mask_sh;
  logic [MAX_COLUMNS-1:0] acc;
  logic                   last_col;

  assign last_col = (CMP_W'(col) + CMP_W'(1)) >= CMP_W'(ctl.width);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      col  <= '0;
      kept <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        col  <= '0;
        kept <= '0;
      end else if (busy) begin
        if (mask_sh[0]) begin
          kept <= kept + LEN_W'(1);
        end
        col <= col + COL_W'(1);
        if (last_col) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      row_sh  <= row_word;
      mask_sh <= mask;
      acc     <= '0;
    end else if (busy) begin
      row_sh  <= row_sh >> 1;
      mask_sh <= mask_sh >> 1;
      if (mask_sh[0]) begin
        acc[kept[COL_W-1:0]] <= row_sh[0];
      end
    end
  end

  assign bits     = acc;
  assign len      = kept;
  assign sts.busy = busy;
  assign sts.done = done;

endmodule

[rtl/blank_row_column_removal_core.sv]
// loading: pixels load at one word per cycle; after the final pixel each kept row
//   passes through scan, read, width compaction steps, packer done and emit, plus
//   any wait on m_tready, and blank rows are skipped at one per cycle in scan
// throughput: one pixel per cycle while loading; no pixel accepted during emission
// reset: sync active-high rst clears control, sets height and width to 64 (clamped)
// ----------------------------------------------------------------------------
// blank_row_column_removal_core
// stores a binary image, then emits the inked rows with blank columns removed
// ----------------------------------------------------------------------------
module blank_row_column_removal_core #(
  parameter int unsigned MAX_ROWS    = brrc_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLUMNS = brrc_pkg::DEF_MAX_COLUMNS
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [brrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brrc_pkg::SIZE_W-1:0]      cfg_data,
  // pixel stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [brrc_pkg::IN_TDATA_W-1:0]  s_tdata,   // [0] pixel, rest zero
  // row stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [brrc_pkg::OUT_TDATA_W-1:0] m_tdata,   // [63:0] row_bits, [70:64] row_length
  output logic                             m_tlast    // last_row
);
  import brrc_pkg::*;

  `include "blank_row_column_removal_core_defines.svh"

  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  // size registers
  logic [SIZE_W-1:0] height;
  logic [SIZE_W-1:0] width;

  // sequencer
  seq_state_t state;
  seq_state_t state_next;

  // load position and ink marks
  logic [ROW_W-1:0]       load_row;
  logic [COL_W-1:0]       load_col;
  logic [MAX_COLUMNS-1:0] row_buf;
  logic [MAX_COLUMNS-1:0] row_wdata;
  logic [MAX_ROWS-1:0]    row_ink;
  logic [MAX_COLUMNS-1:0] col_ink;
  logic                   any_ink;
  logic [ROW_W-1:0]       last_ink;

  // emission row pointer
  logic [ROW_W-1:0]       emit_row;

  // output register
  logic                   out_valid;
  logic [MAX_COLUMNS-1:0] out_bits;
  logic [LEN_W-1:0]       out_len;
  logic                   out_last;

  // datapath links
  logic                   pixel;
  logic                   in_acc;
  logic                   col_end;
  logic                   row_end;
  logic                   final_pix;
  logic                   out_free;
  logic                   emit_last;
  logic                   image_done;
  logic                   clear_image;
  logic                   mem_re;
  logic [MAX_COLUMNS-1:0] mem_rdata;
  pack_ctl_t              pk_ctl;
  pack_sts_t              pk_sts;
  logic [MAX_COLUMNS-1:0] pk_bits;
  logic [LEN_W-1:0]       pk_len;

  assign pixel     = s_tdata[0];
  assign in_acc    = s_tvalid && s_tready;
  assign col_end   = (CMP_W'(load_col) + CMP_W'(1)) >= CMP_W'(width);
  assign row_end   = (CMP_W'(load_row) + CMP_W'(1)) >= CMP_W'(height);
  assign final_pix = in_acc && col_end && row_end;
  assign out_free  = !out_valid || m_tready;
  // the highest inked row closes the image
  assign emit_last = (emit_row == last_ink);

  assign image_done  = ((state == ST_EMIT) && out_free && emit_last) ||
                       ((state == ST_EMPTY) && out_free);
  // any config write abandons a partial image
  assign clear_image = image_done || cfg_we;

  // current row with the incoming pixel merged in, written at row end
  always_comb begin
    row_wdata           = row_buf;
    row_wdata[load_col] = pixel;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (final_pix) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!any_ink) begin
          state_next = ST_EMPTY;
        end else if (row_ink[emit_row]) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_PACK;
      end
      ST_PACK: begin
        if (pk_sts.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = emit_last ? ST_LOAD : ST_SCAN;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready     = 1'b0;
    mem_re       = 1'b0;
    pk_ctl.start = 1'b0;
    pk_ctl.width = width;
    case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
      end
      ST_SCAN: begin
        mem_re = any_ink && row_ink[emit_row];
      end
      ST_READ: begin
        pk_ctl.start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // row store, one full row written per row end
  brrc_row_mem #(
    .DEPTH (MAX_ROWS),
    .WIDTH (MAX_COLUMNS)
  ) u_row_mem (
    .clk   (clk),
    .we    (in_acc && col_end),
    .waddr (load_row),
    .wdata (row_wdata),
    .re    (mem_re),
    .raddr (emit_row),
    .rdata (mem_rdata)
  );

  // shared compaction unit
  brrc_packer #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_packer (
    .clk      (clk),
    .rst      (rst),
    .ctl      (pk_ctl),
    .row_word (mem_rdata),
    .mask     (col_ink),
    .bits     (pk_bits),
    .len      (pk_len),
    .sts      (pk_sts)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      height    <= clamp_size(SIZE_W'(SIZE_RESET), MAX_ROWS);
      width     <= clamp_size(SIZE_W'(SIZE_RESET), MAX_COLUMNS);
      load_row  <= '0;
      load_col  <= '0;
      row_ink   <= '0;
      col_ink   <= '0;
      any_ink   <= 1'b0;
      last_ink  <= '0;
      emit_row  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_HEIGHT: height <= clamp_size(cfg_data, MAX_ROWS);
          REG_WIDTH:  width  <= clamp_size(cfg_data, MAX_COLUMNS);
          default: begin
          end
        endcase
      end

      // load position wraps to zero after the final pixel
      if (clear_image) begin
        load_row <= '0;
        load_col <= '0;
      end else if (in_acc) begin
        load_col <= col_end ? '0 : load_col + COL_W'(1);
        if (col_end) begin
          load_row <= row_end ? '0 : load_row + ROW_W'(1);
        end
      end

      // ink marks; rows load in order so the latest inked row is the last one
      if (clear_image) begin
        row_ink  <= '0;
        col_ink  <= '0;
        any_ink  <= 1'b0;
        last_ink <= '0;
      end else if (in_acc && pixel) begin
        row_ink[load_row] <= 1'b1;
        col_ink[load_col] <= 1'b1;
        any_ink           <= 1'b1;
        last_ink          <= load_row;
      end

      // emission walk, blank rows skipped one per cycle
      if (clear_image) begin
        emit_row <= '0;
      end else if ((state == ST_SCAN) && any_ink && !row_ink[emit_row]) begin
        emit_row <= emit_row + ROW_W'(1);
      end else if ((state == ST_EMIT) && out_free && !emit_last) begin
        emit_row <= emit_row + ROW_W'(1);
      end

      // output word valid
      if (((state == ST_EMIT) || (state == ST_EMPTY)) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_buf[load_col] <= pixel;
    end
    if ((state == ST_EMIT) && out_free) begin
      out_bits <= pk_bits;
      out_len  <= pk_len;
      out_last <= emit_last;
    end else if ((state == ST_EMPTY) && out_free) begin
      // all-background image gives one empty row marked last
      out_bits <= '0;
      out_len  <= '0;
      out_last <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_len, ROW_BITS_W'(out_bits)};
  assign m_tlast  = out_last;

  // checks
  `BRRC_ASSERT_IMPLY(a_pack_done_in_pack, clk, rst, pk_sts.done, state == ST_PACK, "packer done outside pack")
  `BRRC_ASSERT_IMPLY(a_emit_inked_row, clk, rst, state == ST_EMIT, row_ink[emit_row], "emitting a blank row")
  `BRRC_ASSERT_IMPLY(a_scan_bound, clk, rst, (state == ST_SCAN) && any_ink, emit_row <= last_ink, "scan ran past last inked row")
  `BRRC_ASSERT_NEXT(a_clear_after_image, clk, rst, image_done, !any_ink && (load_row == '0), "image state not cleared")

endmodule

[tb/tb_blank_row_column_removal_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_blank_row_column_removal_core
// streams binary images into the core and checks every emitted row against
// an in-bench prediction of the kept rows and columns, under random idling
// ----------------------------------------------------------------------------
module tb_blank_row_column_removal_core;
  import brrc_pkg::*;

  localparam int unsigned ROW_CAP       = 64;   // rows the core can hold
  localparam int unsigned COL_CAP       = 64;   // columns the core can hold
  localparam int          CFG_SETTLE    = 70;   // one full row of packing plus margin
  localparam int          DRAIN_CYCLES  = 100;
  localparam int          STUCK_LIMIT   = 5000; // cycles with no word moving on either side
  localparam int          LONG_HOLD     = 400;
  localparam int          REPORT_MAX    = 10;

  // one emitted row as the checker sees it
  typedef struct packed {
    logic [63:0] row_bits;
    logic [6:0]  row_len;
    logic        last_row;
  } kept_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [SIZE_W-1:0]      cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;    // [0] pixel, rest zero
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;    // [63:0] row_bits, [70:64] row_length, rest zero
  logic                   m_tlast;    // last_row

  blank_row_column_removal_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // rows still owed by the core, oldest first
  kept_row_t expected_rows[$];

  // predicted image state
  logic [63:0] image_rows [0:ROW_CAP-1];
  logic [63:0] inked_rows;
  logic [63:0] inked_cols;
  int unsigned cur_h;
  int unsigned cur_w;
  int unsigned at_row;
  int unsigned at_col;

  int errors;
  int pixels_sent;
  int stuck_cycles;
  int src_idle_pct;
  int dst_idle_pct;
  int hold_req;
  int hold_left;

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------
  // zero acts as one, anything above the capacity acts as the capacity
  function automatic int unsigned fit_size(input logic [SIZE_W-1:0] v, input int unsigned cap);
    if (v == '0) return 1;
    if (int'(v) > cap) return cap;
    return 32'(v);
  endfunction

  task automatic clear_marks();
    inked_rows = '0;
    inked_cols = '0;
    at_row     = 0;
    at_col     = 0;
  endtask

  // any size write drops a partly loaded image
  task automatic apply_size(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    if (idx == REG_HEIGHT) cur_h = fit_size(val, ROW_CAP);
    else if (idx == REG_WIDTH) cur_w = fit_size(val, COL_CAP);
    clear_marks();
  endtask

  // store one pixel; on the final pixel queue up every kept row
  task automatic absorb_pixel(input logic p);
    logic [63:0] used;
    logic [63:0] kept;
    logic [63:0] packed_bits;
    int          kept_len;
    int          k;
    int          last_inked;
    kept_row_t   r;
    image_rows[at_row][at_col] = p;
    if (p) begin
      inked_rows[at_row] = 1'b1;
      inked_cols[at_col] = 1'b1;
    end
    if (at_col + 1 < cur_w) begin
      at_col++;
      return;
    end
    at_col = 0;
    if (at_row + 1 < cur_h) begin
      at_row++;
      return;
    end
    // final pixel: only columns inside the image width count
    used = (cur_w >= 64) ? '1 : ((64'd1 << cur_w) - 64'd1);
    kept = inked_cols & used;
    kept_len = 0;
    for (int j = 0; j < 64; j++) if (kept[j]) kept_len++;
    last_inked = -1;
    for (int i = 0; i < cur_h; i++) if (inked_rows[i]) last_inked = i;
    if (last_inked < 0) begin
      // blank image still yields one empty row marked last
      r.row_bits = '0;
      r.row_len  = '0;
      r.last_row = 1'b1;
      expected_rows.push_back(r);
    end else begin
      for (int i = 0; i < cur_h; i++) begin
        if (inked_rows[i]) begin
          packed_bits = '0;
          k = 0;
          for (int j = 0; j < cur_w; j++) begin
            if (kept[j]) begin
              packed_bits[k] = image_rows[i][j];
              k++;
            end
          end
          r.row_bits = packed_bits;
          r.row_len  = 7'(kept_len);
          r.last_row = (i == last_inked);
          expected_rows.push_back(r);
        end
      end
    end
    clear_marks();
  endtask

  // ---------------------------------------------------------------------------
  // pixel side
  // ---------------------------------------------------------------------------
  // offer one pixel word, with random idle cycles ahead of it, until taken
  task automatic send_pixel(input logic p);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W-1){1'b0}}, p};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    absorb_pixel(p);
    pixels_sent++;
  endtask

  // pattern bit n is the n-th pixel in row-major order
  task automatic send_pattern(input logic [63:0] pattern, input int n);
    for (int i = 0; i < n; i++) send_pixel(pattern[i]);
  endtask

  // one whole image at the current size, ink with the given percentage
  task automatic send_image(input int ink_pct);
    int n;
    n = cur_h * cur_w;
    for (int i = 0; i < n; i++) send_pixel($urandom_range(99) < ink_pct);
  endtask

  // size writes only once the core has emitted everything and settled
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    s_tvalid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    apply_size(idx, val);
  endtask

  // ---------------------------------------------------------------------------
  // row side: ready pattern, with an optional long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // compare every accepted row word with the oldest prediction
  always @(posedge clk) begin
    kept_row_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_rows.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected row: bits %h len %0d last %b",
                   m_tdata[63:0], m_tdata[70:64], m_tlast);
      end else begin
        want = expected_rows.pop_front();
        if (m_tdata[63:0] !== want.row_bits || m_tdata[70:64] !== want.row_len ||
            m_tlast !== want.last_row) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("row mismatch: expected bits %h len %0d last %b, got bits %h len %0d last %b",
                     want.row_bits, want.row_len, want.last_row,
                     m_tdata[63:0], m_tdata[70:64], m_tlast);
        end
      end
    end
  end

  // watchdog: too long with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb_blank_row_column_removal_core NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // hand-picked images: 1x1 both ways, blank row and column, blank image,
  // abandoned image, kept column holding a zero
  task automatic test_directed();
    write_reg(REG_HEIGHT, 7'd0);   // zero acts as one
    write_reg(REG_WIDTH, 7'd1);
    send_pattern(64'b1, 1);
    send_pattern(64'b0, 1);
    write_reg(REG_HEIGHT, 7'd2);
    write_reg(REG_WIDTH, 7'd3);
    send_pattern(64'b000_101, 6);  // middle column and second row blank
    send_pattern(64'b0, 6);        // all background
    send_pattern(64'b11, 2);       // dropped by the next write
    write_reg(REG_HEIGHT, 7'd3);
    write_reg(REG_WIDTH, 7'd3);
    send_pattern(64'h101, 9);      // corners: rows 01 and 10
  endtask

  // full-width and full-height images, sizes above the limit and zero
  task automatic test_size_extremes();
    write_reg(REG_HEIGHT, 7'd1);
    write_reg(REG_WIDTH, 7'd127);  // acts as 64
    send_image(50);
    write_reg(REG_HEIGHT, 7'd65);  // acts as 64
    write_reg(REG_WIDTH, 7'd0);    // acts as one
    send_image(10);                // mostly blank rows to skip
  endtask

  // receiver holds off while the sender keeps offering the next image
  task automatic test_backpressure();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    write_reg(REG_HEIGHT, 7'd4);
    write_reg(REG_WIDTH, 7'd5);
    hold_req = LONG_HOLD;
    send_image(80);
    send_image(60);
    send_image(30);
  endtask

  // one image of random size and content, sometimes cut short by a write
  task automatic random_image();
    int h;
    int w;
    int ink_pct;
    int n;
    int cut;
    case ($urandom_range(9))
      0: begin
        h = $urandom_range(1, 2);
        w = $urandom_range(9, 64);
      end
      1: begin
        h = 0;
        w = $urandom_range(0, 10);
      end
      default: begin
        h = $urandom_range(1, 6);
        w = $urandom_range(1, 8);
      end
    endcase
    // otherwise the image follows the previous one back to back
    if ($urandom_range(3) != 0) begin
      write_reg(REG_HEIGHT, 7'(h));
      write_reg(REG_WIDTH, 7'(w));
    end
    case ($urandom_range(3))
      0:       ink_pct = 0;
      1:       ink_pct = 12;
      2:       ink_pct = 50;
      default: ink_pct = 88;
    endcase
    n = cur_h * cur_w;
    if (n > 1 && $urandom_range(11) == 0) begin
      cut = $urandom_range(1, n - 1);
      for (int i = 0; i < cut; i++) send_pixel($urandom_range(99) < ink_pct);
      write_reg(REG_WIDTH, 7'(cur_w));
    end else begin
      send_image(ink_pct);
    end
  endtask

  task automatic test_random_traffic(input int src_pct, input int dst_pct, input int goal);
    int pix_start;
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    pix_start  = pixels_sent;
    while (pixels_sent - pix_start < goal) random_image();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b0;
    errors       = 0;
    pixels_sent  = 0;
    stuck_cycles = 0;
    hold_req     = 0;
    hold_left    = 0;
    src_idle_pct = 25;
    dst_idle_pct = 58;
    cur_h        = 64;
    cur_w        = 64;
    clear_marks();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_size_extremes();
    test_random_traffic(25, 58, 55);
    test_random_traffic(58, 25, 55);
    test_random_traffic(0, 0, 55);
    test_backpressure();

    // drain: everything owed, then a quiet stretch for stray rows
    s_tvalid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_blank_row_column_removal_core OK");
    end else begin
      $display("tb_blank_row_column_removal_core NOT OK");
    end
    $finish;
  end

endmodule
